// ----- rtl/fdm_pkg.sv -----
// Shared types, constants and helper functions for the floppy drive mechanics unit.
// No dependencies; used by fdm_cfg, fdm_core and floppy_drive_mechanics_unit.
`default_nettype none

package fdm_pkg;

  // Head travel and timer limits
  localparam logic [6:0]  MAX_CYLINDER = 7'd83;
  localparam logic [10:0] SETTLE_MAX   = 11'h7FF;
  localparam logic [15:0] FULL_SPEED   = 16'hFFFF;

  // Identification words
  localparam logic [31:0] ID_NONE = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_HD   = 32'hAAAA_AAAA;
  localparam logic [31:0] ID_525  = 32'h5555_5555;
  localparam logic [31:0] ID_INT  = 32'h0000_0000;

  // Status byte bit positions (active low)
  localparam int unsigned ST_READY   = 5;
  localparam int unsigned ST_TRACK0  = 4;
  localparam int unsigned ST_PROTECT = 3;
  localparam int unsigned ST_CHANGE  = 2;

  // Port byte bit positions
  localparam int unsigned PB_MTR  = 7;
  localparam int unsigned PB_SIDE = 2;
  localparam int unsigned PB_DIR  = 1;
  localparam int unsigned PB_STEP = 0;
  localparam logic [2:0]  PB_SEL0 = 3'd3;

  // Request modes
  typedef enum logic [2:0] {
    MODE_PORT   = 3'd0,
    MODE_TICK   = 3'd1,
    MODE_BYTE   = 3'd2,
    MODE_INSERT = 3'd3,
    MODE_EJECT  = 3'd4
  } mode_t;

  // Drive kinds
  localparam logic [1:0] KIND_DD35  = 2'd0;
  localparam logic [1:0] KIND_HD35  = 2'd1;
  localparam logic [1:0] KIND_DD525 = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_DRIVE_NUMBER = 3'd0;
  localparam logic [2:0] REG_DRIVE_KIND   = 3'd1;
  localparam logic [2:0] REG_MECHANICS_ON = 3'd2;
  localparam logic [2:0] REG_SPIN_UP      = 3'd3;
  localparam logic [2:0] REG_SPIN_DOWN    = 3'd4;
  localparam logic [2:0] REG_SETTLE       = 3'd5;
  localparam logic [2:0] REG_TRACK_BYTES  = 3'd6;

  // Configuration reset values
  localparam logic [10:0] SETTLE_RESET = 11'd1060;
  localparam logic [13:0] TRACK_RESET  = 14'd12668;

  typedef struct packed {
    logic [1:0]  drive_number;
    logic [1:0]  drive_kind;
    logic        mechanics_on;
    logic [15:0] spin_up_rate;
    logic [15:0] spin_down_rate;
    logic [10:0] step_settle_ticks;
    logic [13:0] track_bytes;
  } cfg_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] port_value;
    logic       disk_small;
    logic       disk_high_density;
    logic       disk_locked;
  } item_t;

  typedef struct packed {
    logic [7:0]  status_byte;
    logic [6:0]  cylinder;
    logic        side;
    logic [13:0] head_offset;
    logic        motor_running;
    logic        index_pulse;
    logic        insert_ok;
  } result_t;

  // Active-low select bit of this drive in a port byte
  function automatic logic sel_bit(input logic [7:0] port, input logic [1:0] drv);
    logic [2:0] idx;
    idx = PB_SEL0 + {1'b0, drv};
    return port[idx];
  endfunction

  // Speed seen by the rest of the logic
  function automatic logic [15:0] eff_speed(input logic mech, input logic motor,
                                            input logic [15:0] spin);
    logic [15:0] sp;
    if (mech) sp = spin;
    else      sp = motor ? FULL_SPEED : 16'd0;
    return sp;
  endfunction

  // One bit of the identification word, MSB first
  function automatic logic ident_bit(input logic [1:0] drv, input logic [1:0] kind,
                                     input logic disk_in, input logic disk_hd,
                                     input logic [4:0] pos);
    logic [31:0] word;
    if (drv == 2'd0)            word = ID_INT;
    else if (kind == KIND_HD35) word = (disk_in && disk_hd) ? ID_HD : ID_NONE;
    else if (kind == KIND_DD525) word = ID_525;
    else                        word = ID_NONE;
    return word[5'd31 - pos];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/floppy_drive_mechanics_unit.sv -----
// Floppy drive mechanics unit: top level with input and result registers.
// Depends on fdm_pkg, fdm_cfg and fdm_core.
//
// Usage:
//   Requests enter on the in_ channel (valid/ready): a port byte write, a
//   timebase tick, a byte passing the head, a disk insert or an eject. Every
//   request yields exactly one result on the out_ channel (valid/ready):
//   the active-low status byte, cylinder, side, offset within the track,
//   motor state, index pulse and insert acknowledge.
//   Configuration registers are written on the cfg_ channel, always ready,
//   and should be written only while no request is in flight.
//   Timing: an accepted request is captured in the input register; once the
//   result register is free or being read, the drive state is updated and the
//   result is loaded into the result register, which raises out_valid.
//   Throughput: one request per cycle while the receiver takes results; the
//   state update between the input and result registers is combinational.
//   When the receiver stalls, the result holds; one more request can wait in
//   the input register, after which in_ready drops.
//   Reset (rst_n low, synchronous) empties both registers, returns the drive
//   state to no disk, motor off, cylinder 0 with the settle timer saturated,
//   and loads the configuration defaults.
`default_nettype none

module floppy_drive_mechanics_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_port_value,
  input  wire logic        in_disk_small,
  input  wire logic        in_disk_high_density,
  input  wire logic        in_disk_locked,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_status_byte,
  output logic [6:0]       out_cylinder,
  output logic             out_side,
  output logic [13:0]      out_head_offset,
  output logic             out_motor_running,
  output logic             out_index_pulse,
  output logic             out_insert_ok,
  // configuration channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  fdm_pkg::cfg_t    cfg;
  fdm_pkg::item_t   item_r, item_nxt;
  fdm_pkg::result_t res;
  fdm_pkg::result_t res_r;
  logic             in_vld_r, in_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             advance;
  logic             process;

  assign cfg_ready = 1'b1;

  fdm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Pipeline control: result slot free or being taken
  assign advance  = !out_vld_r || out_ready;
  assign process  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_comb begin
    item_nxt.mode              = in_mode;
    item_nxt.port_value        = in_port_value;
    item_nxt.disk_small        = in_disk_small;
    item_nxt.disk_high_density = in_disk_high_density;
    item_nxt.disk_locked       = in_disk_locked;
    if (in_valid && in_ready) in_vld_nxt = 1'b1;
    else if (process)         in_vld_nxt = 1'b0;
    else                      in_vld_nxt = in_vld_r;
    if (process)        out_vld_nxt = 1'b1;
    else if (out_ready) out_vld_nxt = 1'b0;
    else                out_vld_nxt = out_vld_r;
  end

  fdm_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .process (process),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= item_nxt;
    if (process)              res_r  <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_status_byte   = res_r.status_byte;
  assign out_cylinder      = res_r.cylinder;
  assign out_side          = res_r.side;
  assign out_head_offset   = res_r.head_offset;
  assign out_motor_running = res_r.motor_running;
  assign out_index_pulse   = res_r.index_pulse;
  assign out_insert_ok     = res_r.insert_ok;

endmodule

`default_nettype wire

// ----- rtl/fdm_cfg.sv -----
// Configuration register file of the drive mechanics unit.
// Depends on fdm_pkg (cfg_t, register indexes, reset values).
`default_nettype none

module fdm_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire logic [2:0]    wr_index,
  input  wire logic [15:0]   wr_data,
  output fdm_pkg::cfg_t      cfg
);

  fdm_pkg::cfg_t cfg_r;
  fdm_pkg::cfg_t cfg_nxt;

  // Decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        fdm_pkg::REG_DRIVE_NUMBER: cfg_nxt.drive_number      = wr_data[1:0];
        fdm_pkg::REG_DRIVE_KIND:   cfg_nxt.drive_kind        = wr_data[1:0];
        fdm_pkg::REG_MECHANICS_ON: cfg_nxt.mechanics_on      = wr_data[0];
        fdm_pkg::REG_SPIN_UP:      cfg_nxt.spin_up_rate      = wr_data;
        fdm_pkg::REG_SPIN_DOWN:    cfg_nxt.spin_down_rate    = wr_data;
        fdm_pkg::REG_SETTLE:       cfg_nxt.step_settle_ticks = wr_data[10:0];
        fdm_pkg::REG_TRACK_BYTES:  cfg_nxt.track_bytes       = wr_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.drive_number      <= 2'd0;
      cfg_r.drive_kind        <= fdm_pkg::KIND_DD35;
      cfg_r.mechanics_on      <= 1'b1;
      cfg_r.spin_up_rate      <= 16'd1;
      cfg_r.spin_down_rate    <= 16'd1;
      cfg_r.step_settle_ticks <= fdm_pkg::SETTLE_RESET;
      cfg_r.track_bytes       <= fdm_pkg::TRACK_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/fdm_core.sv -----
// Drive state and single-pass update logic: one request per strobe.
// Depends on fdm_pkg (item_t, result_t, cfg_t, helper functions, constants).
`default_nettype none

module fdm_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          process,
  input  wire fdm_pkg::item_t item,
  input  wire fdm_pkg::cfg_t  cfg,
  output fdm_pkg::result_t   res
);

  logic [7:0]  last_port_r, last_port_nxt;
  logic [6:0]  cyl_r, cyl_nxt;
  logic        side_r, side_nxt;
  logic [13:0] offset_r, offset_nxt;
  logic        motor_r, motor_nxt;
  logic [15:0] spin_r, spin_nxt;
  logic [4:0]  id_pos_r, id_pos_nxt;
  logic        id_out_r, id_out_nxt;
  logic        disk_in_r, disk_in_nxt;
  logic        disk_hd_r, disk_hd_nxt;
  logic        protect_r, protect_nxt;
  logic        change_r, change_nxt;
  logic [10:0] settle_r, settle_nxt;

  // Next state and result for the request in the input register
  always_comb begin
    logic        old_sel;
    logic        new_sel;
    logic        motor_on;
    logic        step_ready;
    logic        fit;
    logic [16:0] up_sum;
    logic [14:0] next_off;
    logic [15:0] sp;
    logic        stopped;
    logic        full;
    logic        id_mode;
    logic [7:0]  st;
    logic        pulse;
    logic        ok;

    last_port_nxt = last_port_r;
    cyl_nxt       = cyl_r;
    side_nxt      = side_r;
    offset_nxt    = offset_r;
    motor_nxt     = motor_r;
    spin_nxt      = spin_r;
    id_pos_nxt    = id_pos_r;
    id_out_nxt    = id_out_r;
    disk_in_nxt   = disk_in_r;
    disk_hd_nxt   = disk_hd_r;
    protect_nxt   = protect_r;
    change_nxt    = change_r;
    settle_nxt    = settle_r;
    pulse         = 1'b0;
    ok            = 1'b0;
    old_sel       = fdm_pkg::sel_bit(last_port_r, cfg.drive_number);
    new_sel       = fdm_pkg::sel_bit(item.port_value, cfg.drive_number);
    motor_on      = 1'b0;
    step_ready    = 1'b0;
    fit           = 1'b0;
    up_sum        = {1'b0, spin_r} + {1'b0, cfg.spin_up_rate};
    next_off      = {1'b0, offset_r} + 15'd1;

    case (item.mode)
      fdm_pkg::MODE_PORT: begin
        last_port_nxt = item.port_value;
        // Falling select edge: shift ID, switch motor
        if (old_sel && !new_sel) begin
          id_pos_nxt = id_pos_r + 5'd1;
          id_out_nxt = fdm_pkg::ident_bit(cfg.drive_number, cfg.drive_kind,
                                          disk_in_r, disk_hd_r, id_pos_nxt);
          motor_on = !last_port_r[fdm_pkg::PB_MTR] || !item.port_value[fdm_pkg::PB_MTR];
          if (motor_r != motor_on) begin
            spin_nxt   = fdm_pkg::eff_speed(cfg.mechanics_on, motor_r, spin_r);
            motor_nxt  = motor_on;
            id_pos_nxt = 5'd0;
          end
        end
        // Rising STEP edge while selected
        if (!last_port_r[fdm_pkg::PB_STEP] && item.port_value[fdm_pkg::PB_STEP] &&
            !old_sel) begin
          if (disk_in_r) change_nxt = 1'b1;
          step_ready = !cfg.mechanics_on || (settle_r > cfg.step_settle_ticks) ||
                       (settle_r == fdm_pkg::SETTLE_MAX);
          if (step_ready) begin
            if (item.port_value[fdm_pkg::PB_DIR]) begin
              if (cyl_r != 7'd0) cyl_nxt = cyl_r - 7'd1;
            end else begin
              if (cyl_r < fdm_pkg::MAX_CYLINDER) cyl_nxt = cyl_r + 7'd1;
            end
            settle_nxt = 11'd0;
          end
        end
        side_nxt = !item.port_value[fdm_pkg::PB_SIDE];
      end
      fdm_pkg::MODE_TICK: begin
        // Linear spin-up / spin-down, saturating
        if (motor_r) begin
          spin_nxt = up_sum[16] ? fdm_pkg::FULL_SPEED : up_sum[15:0];
        end else begin
          spin_nxt = (spin_r > cfg.spin_down_rate) ? spin_r - cfg.spin_down_rate : 16'd0;
        end
        if (settle_r != fdm_pkg::SETTLE_MAX) settle_nxt = settle_r + 11'd1;
      end
      fdm_pkg::MODE_BYTE: begin
        // Track rotation with index pulse on wrap while selected
        if (motor_r) begin
          if (next_off >= {1'b0, cfg.track_bytes}) begin
            offset_nxt = 14'd0;
            pulse      = !old_sel;
          end else begin
            offset_nxt = next_off[13:0];
          end
        end
      end
      fdm_pkg::MODE_INSERT: begin
        case (cfg.drive_kind)
          fdm_pkg::KIND_DD35:  fit = !item.disk_small && !item.disk_high_density;
          fdm_pkg::KIND_HD35:  fit = !item.disk_small;
          fdm_pkg::KIND_DD525: fit = item.disk_small && !item.disk_high_density;
          default:             fit = 1'b0;
        endcase
        if (fit && !disk_in_r) begin
          disk_in_nxt = 1'b1;
          disk_hd_nxt = item.disk_high_density;
          protect_nxt = item.disk_locked;
          offset_nxt  = 14'd0;
          ok          = 1'b1;
        end
      end
      fdm_pkg::MODE_EJECT: begin
        if (disk_in_r) begin
          change_nxt  = 1'b0;
          disk_in_nxt = 1'b0;
          disk_hd_nxt = 1'b0;
          protect_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // Status byte from the updated state
    sp      = fdm_pkg::eff_speed(cfg.mechanics_on, motor_nxt, spin_nxt);
    stopped = (sp == 16'd0);
    full    = (sp == fdm_pkg::FULL_SPEED);
    id_mode = stopped || (motor_nxt && !full);
    st      = 8'hFF;
    if (!fdm_pkg::sel_bit(last_port_nxt, cfg.drive_number)) begin
      if (id_mode) begin
        if (id_out_nxt) st[fdm_pkg::ST_READY] = 1'b0;
      end else if (disk_in_nxt) begin
        if (full || (!motor_nxt && !stopped)) st[fdm_pkg::ST_READY] = 1'b0;
      end
      if (cyl_nxt == 7'd0) st[fdm_pkg::ST_TRACK0] = 1'b0;
      if (!(disk_in_nxt && !protect_nxt)) st[fdm_pkg::ST_PROTECT] = 1'b0;
      if (!change_nxt) st[fdm_pkg::ST_CHANGE] = 1'b0;
    end

    res.status_byte   = st;
    res.cylinder      = cyl_nxt;
    res.side          = side_nxt;
    res.head_offset   = offset_nxt;
    res.motor_running = motor_nxt;
    res.index_pulse   = pulse;
    res.insert_ok     = ok;
  end

  // Drive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_port_r <= 8'hFF;
      cyl_r       <= 7'd0;
      side_r      <= 1'b0;
      offset_r    <= 14'd0;
      motor_r     <= 1'b0;
      spin_r      <= 16'd0;
      id_pos_r    <= 5'd0;
      id_out_r    <= 1'b0;
      disk_in_r   <= 1'b0;
      disk_hd_r   <= 1'b0;
      protect_r   <= 1'b0;
      change_r    <= 1'b0;
      settle_r    <= fdm_pkg::SETTLE_MAX;
    end else if (process) begin
      last_port_r <= last_port_nxt;
      cyl_r       <= cyl_nxt;
      side_r      <= side_nxt;
      offset_r    <= offset_nxt;
      motor_r     <= motor_nxt;
      spin_r      <= spin_nxt;
      id_pos_r    <= id_pos_nxt;
      id_out_r    <= id_out_nxt;
      disk_in_r   <= disk_in_nxt;
      disk_hd_r   <= disk_hd_nxt;
      protect_r   <= protect_nxt;
      change_r    <= change_nxt;
      settle_r    <= settle_nxt;
    end
  end

  // Head never leaves the cylinder range
  a_cyl_range: assert property (@(posedge clk) disable iff (!rst_n)
    cyl_r <= fdm_pkg::MAX_CYLINDER)
    else $error("head cylinder out of range");

  // An accepted insert leaves a disk in the drive
  a_insert_disk: assert property (@(posedge clk) disable iff (!rst_n)
    process && res.insert_ok |=> disk_in_r)
    else $error("insert accepted but no disk latched");

  // A tick advances an unsaturated settle timer by one
  a_settle_tick: assert property (@(posedge clk) disable iff (!rst_n)
    process && (item.mode == fdm_pkg::MODE_TICK) && (settle_r != fdm_pkg::SETTLE_MAX)
    |=> settle_r == $past(settle_r) + 11'd1)
    else $error("settle timer did not advance on tick");

  // Status flags only show while the drive is selected
  a_status_sel: assert property (@(posedge clk) disable iff (!rst_n)
    process && (res.status_byte != 8'hFF)
    |-> !fdm_pkg::sel_bit(last_port_nxt, cfg.drive_number))
    else $error("status flags shown while deselected");

endmodule

`default_nettype wire

// ----- verif/tb_floppy_drive_mechanics_unit.sv -----
// Self-checking testbench for floppy_drive_mechanics_unit: drives port writes, ticks,
// byte passes, inserts and ejects and checks every result against a local drive model.
// Depends on fdm_pkg and the RTL of floppy_drive_mechanics_unit only.
`timescale 1ns / 1ps

module tb_floppy_drive_mechanics_unit;

  // Modes outside the defined set, and the drive kind that accepts no disk
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [1:0] KIND_NONE        = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;
  localparam int PRINT_LIMIT    = 40;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode = '0;
  logic [7:0]  in_port_value = '0;
  logic        in_disk_small = 1'b0;
  logic        in_disk_high_density = 1'b0;
  logic        in_disk_locked = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_status_byte;
  logic [6:0]  out_cylinder;
  logic        out_side;
  logic [13:0] out_head_offset;
  logic        out_motor_running;
  logic        out_index_pulse;
  logic        out_insert_ok;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  floppy_drive_mechanics_unit dut (.*);

  // Drive model state and its copy of the registers
  fdm_pkg::cfg_t m_cfg;
  logic [7:0]  m_port;
  logic [6:0]  m_cyl;
  logic        m_side;
  logic [13:0] m_offset;
  logic        m_motor;
  logic [15:0] m_speed;
  logic [4:0]  m_id_pos;
  logic        m_id_bit;
  logic        m_disk;
  logic        m_disk_hd;
  logic        m_disk_wp;
  logic        m_changed;
  logic [10:0] m_settle;

  fdm_pkg::result_t awaited_reports[$];
  fdm_pkg::result_t want_r;
  int      tx_idle_pct = 15;
  int      rx_idle_pct = 45;
  int      stall_request = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- drive model

  function automatic void reset_model();
    m_cfg = '{drive_number: 2'd0, drive_kind: fdm_pkg::KIND_DD35, mechanics_on: 1'b1,
              spin_up_rate: 16'd1, spin_down_rate: 16'd1,
              step_settle_ticks: fdm_pkg::SETTLE_RESET,
              track_bytes: fdm_pkg::TRACK_RESET};
    m_port = 8'hFF;  m_cyl = '0;     m_side = 1'b0;    m_offset = '0;
    m_motor = 1'b0;  m_speed = '0;   m_id_pos = '0;    m_id_bit = 1'b0;
    m_disk = 1'b0;   m_disk_hd = 1'b0; m_disk_wp = 1'b0; m_changed = 1'b0;
    m_settle = fdm_pkg::SETTLE_MAX;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      fdm_pkg::REG_DRIVE_NUMBER: m_cfg.drive_number      = data[1:0];
      fdm_pkg::REG_DRIVE_KIND:   m_cfg.drive_kind        = data[1:0];
      fdm_pkg::REG_MECHANICS_ON: m_cfg.mechanics_on      = data[0];
      fdm_pkg::REG_SPIN_UP:      m_cfg.spin_up_rate      = data;
      fdm_pkg::REG_SPIN_DOWN:    m_cfg.spin_down_rate    = data;
      fdm_pkg::REG_SETTLE:       m_cfg.step_settle_ticks = data[10:0];
      fdm_pkg::REG_TRACK_BYTES:  m_cfg.track_bytes       = data[13:0];
      default: ;
    endcase
  endfunction

  // active-low select bit of the configured drive
  function automatic logic deselected(input logic [7:0] port);
    return port[fdm_pkg::PB_SEL0 + {1'b0, m_cfg.drive_number}];
  endfunction

  function automatic logic [7:0] sel_mask();
    return 8'd1 << (fdm_pkg::PB_SEL0 + {1'b0, m_cfg.drive_number});
  endfunction

  // with mechanics off the motor is either stopped or at full speed
  function automatic logic [15:0] speed_seen();
    if (!m_cfg.mechanics_on) return m_motor ? fdm_pkg::FULL_SPEED : 16'd0;
    return m_speed;
  endfunction

  function automatic logic [31:0] id_word();
    if (m_cfg.drive_number == 2'd0) return fdm_pkg::ID_INT;
    case (m_cfg.drive_kind)
      fdm_pkg::KIND_HD35:  return (m_disk && m_disk_hd) ? fdm_pkg::ID_HD : fdm_pkg::ID_NONE;
      fdm_pkg::KIND_DD525: return fdm_pkg::ID_525;
      default:             return fdm_pkg::ID_NONE;
    endcase
  endfunction

  function automatic void switch_motor(input logic on);
    if (m_motor == on) return;
    m_speed  = speed_seen();
    m_motor  = on;
    m_id_pos = '0;
  endfunction

  // every attempt with a disk in marks a disk change; the head moves only once settled or with mechanics off
  function automatic void step_head(input logic outward);
    if (m_disk) m_changed = 1'b1;
    if (m_cfg.mechanics_on && !(m_settle > m_cfg.step_settle_ticks) &&
        m_settle != fdm_pkg::SETTLE_MAX) return;
    if (outward) begin
      if (m_cyl != '0) m_cyl = m_cyl - 7'd1;
    end else if (m_cyl < fdm_pkg::MAX_CYLINDER) begin
      m_cyl = m_cyl + 7'd1;
    end
    m_settle = '0;
  endfunction

  function automatic logic [7:0] drive_status();
    logic [7:0]  s;
    logic [15:0] seen;
    logic        id_phase;
    s = 8'hFF;
    seen = speed_seen();
    id_phase = (seen == 16'd0) || (m_motor && seen != fdm_pkg::FULL_SPEED);
    if (deselected(m_port)) return s;
    if (id_phase) begin
      if (m_id_bit) s[fdm_pkg::ST_READY] = 1'b0;
    end else if (m_disk && (seen == fdm_pkg::FULL_SPEED ||
                            (!m_motor && seen != 16'd0))) begin
      s[fdm_pkg::ST_READY] = 1'b0;
    end
    if (m_cyl == '0) s[fdm_pkg::ST_TRACK0] = 1'b0;
    if (!(m_disk && !m_disk_wp)) s[fdm_pkg::ST_PROTECT] = 1'b0;
    if (!m_changed) s[fdm_pkg::ST_CHANGE] = 1'b0;
    return s;
  endfunction

  // Applies one request to the model and returns the report it must produce
  function automatic fdm_pkg::result_t advance_drive(input fdm_pkg::item_t it);
    fdm_pkg::result_t r;
    logic [7:0]  prev;
    logic        was_off;
    logic [31:0] word;
    logic [16:0] sum;
    logic [14:0] nxt;
    logic        fits;
    r = '0;
    case (it.mode)
      fdm_pkg::MODE_PORT: begin
        prev = m_port;
        was_off = deselected(prev);
        m_port = it.port_value;
        if (was_off && !deselected(it.port_value)) begin
          m_id_pos = m_id_pos + 5'd1;
          word = id_word();
          m_id_bit = word[5'd31 - m_id_pos];
          switch_motor(!prev[fdm_pkg::PB_MTR] || !it.port_value[fdm_pkg::PB_MTR]);
        end
        if (!prev[fdm_pkg::PB_STEP] && it.port_value[fdm_pkg::PB_STEP] && !was_off)
          step_head(it.port_value[fdm_pkg::PB_DIR]);
        m_side = !it.port_value[fdm_pkg::PB_SIDE];
      end
      fdm_pkg::MODE_TICK: begin
        if (m_motor) begin
          sum = {1'b0, m_speed} + {1'b0, m_cfg.spin_up_rate};
          m_speed = sum[16] ? fdm_pkg::FULL_SPEED : sum[15:0];
        end else begin
          m_speed = (m_speed > m_cfg.spin_down_rate) ? m_speed - m_cfg.spin_down_rate : '0;
        end
        if (m_settle != fdm_pkg::SETTLE_MAX) m_settle = m_settle + 11'd1;
      end
      fdm_pkg::MODE_BYTE: begin
        if (m_motor) begin
          nxt = {1'b0, m_offset} + 15'd1;
          if (nxt >= {1'b0, m_cfg.track_bytes}) begin
            nxt = '0;
            if (!deselected(m_port)) r.index_pulse = 1'b1;
          end
          m_offset = nxt[13:0];
        end
      end
      fdm_pkg::MODE_INSERT: begin
        case (m_cfg.drive_kind)
          fdm_pkg::KIND_DD35:  fits = !it.disk_small && !it.disk_high_density;
          fdm_pkg::KIND_HD35:  fits = !it.disk_small;
          fdm_pkg::KIND_DD525: fits = it.disk_small && !it.disk_high_density;
          default:             fits = 1'b0;
        endcase
        if (fits && !m_disk) begin
          m_disk = 1'b1;
          m_disk_hd = it.disk_high_density;
          m_disk_wp = it.disk_locked;
          m_offset = '0;
          r.insert_ok = 1'b1;
        end
      end
      fdm_pkg::MODE_EJECT: begin
        if (m_disk) begin
          m_changed = 1'b0;
          m_disk = 1'b0;
          m_disk_hd = 1'b0;
          m_disk_wp = 1'b0;
        end
      end
      default: ;
    endcase
    r.status_byte   = drive_status();
    r.cylinder      = m_cyl;
    r.side          = m_side;
    r.head_offset   = m_offset;
    r.motor_running = m_motor;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) report_mismatch(what, want, got);
  endtask

  // compare each accepted report with the oldest one predicted
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("report with no request pending", 0, 0);
      end else begin
        want_r = awaited_reports.pop_front();
        check_field("status_byte", want_r.status_byte, out_status_byte);
        check_field("cylinder", want_r.cylinder, out_cylinder);
        check_field("side", want_r.side, out_side);
        check_field("head_offset", want_r.head_offset, out_head_offset);
        check_field("motor_running", want_r.motor_running, out_motor_running);
        check_field("index_pulse", want_r.index_pulse, out_index_pulse);
        check_field("insert_ok", want_r.insert_ok, out_insert_ok);
      end
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (stall_left == 0 && stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog: too long without any handshake ends the run
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("timeout after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- drivers

  function automatic fdm_pkg::item_t make_item(input logic [2:0] mode, input logic [7:0] pv,
                                               input logic sm, input logic hd,
                                               input logic lk);
    fdm_pkg::item_t it;
    it.mode = mode;
    it.port_value = pv;
    it.disk_small = sm;
    it.disk_high_density = hd;
    it.disk_locked = lk;
    return it;
  endfunction

  // send one request, predict its report on acceptance, then maybe idle
  task automatic push_request(input fdm_pkg::item_t it);
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_port_value <= it.port_value;
    in_disk_small <= it.disk_small;
    in_disk_high_density <= it.disk_high_density;
    in_disk_locked <= it.disk_locked;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_reports.push_back(advance_drive(it));
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic push_port(input logic [7:0] pv);
    push_request(make_item(fdm_pkg::MODE_PORT, pv, 1'b0, 1'b0, 1'b0));
  endtask

  // deselect then select the drive, with the given motor bits
  task automatic select_pulse(input logic mtr_first, input logic mtr_second);
    logic [7:0] p;
    p = 8'($urandom_range(255)) | sel_mask();
    p[fdm_pkg::PB_MTR] = mtr_first;
    push_port(p);
    p = 8'($urandom_range(255)) & ~sel_mask();
    p[fdm_pkg::PB_MTR] = mtr_second;
    push_port(p);
  endtask

  // STEP low then high while selected
  task automatic step_pulse(input logic outward);
    logic [7:0] p;
    p = 8'($urandom_range(255)) & ~sel_mask();
    p[fdm_pkg::PB_DIR] = outward;
    p[fdm_pkg::PB_STEP] = 1'b0;
    push_port(p);
    p[fdm_pkg::PB_STEP] = 1'b1;
    push_port(p);
  endtask

  task automatic wait_drive_quiet();
    in_valid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic program_setting(input fdm_pkg::cfg_t c);
    wait_drive_quiet();
    write_reg(fdm_pkg::REG_DRIVE_NUMBER, 16'(c.drive_number));
    write_reg(fdm_pkg::REG_DRIVE_KIND, 16'(c.drive_kind));
    write_reg(fdm_pkg::REG_MECHANICS_ON, 16'(c.mechanics_on));
    write_reg(fdm_pkg::REG_SPIN_UP, c.spin_up_rate);
    write_reg(fdm_pkg::REG_SPIN_DOWN, c.spin_down_rate);
    write_reg(fdm_pkg::REG_SETTLE, 16'(c.step_settle_ticks));
    write_reg(fdm_pkg::REG_TRACK_BYTES, 16'(c.track_bytes));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(4))
      0:       return 16'd1;
      1:       return fdm_pkg::FULL_SPEED;
      2:       return 16'($urandom_range(30000, 2000));
      3:       return 16'($urandom_range(200, 1));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic fdm_pkg::cfg_t random_setting();
    fdm_pkg::cfg_t c;
    c.drive_number = 2'($urandom_range(3));
    c.drive_kind = ($urandom_range(9) == 0) ? KIND_NONE : 2'($urandom_range(2));
    c.mechanics_on = 1'($urandom_range(1));
    c.spin_up_rate = pick_rate();
    c.spin_down_rate = pick_rate();
    case ($urandom_range(3))
      0:       c.step_settle_ticks = '0;
      1:       c.step_settle_ticks = fdm_pkg::SETTLE_MAX;
      default: c.step_settle_ticks = 11'($urandom_range(12, 1));
    endcase
    case ($urandom_range(5))
      0:       c.track_bytes = '0;
      1:       c.track_bytes = 14'd1;
      default: c.track_bytes = 14'($urandom_range(40, 2));
    endcase
    return c;
  endfunction

  // Well-formed select and step sequences, tick and byte bursts and ejects;
  // inserts favor disks the drive kind takes; the rest is random noise.
  task automatic run_traffic(input int n);
    int   sent;
    int   pick;
    int   reps;
    logic dir;
    logic sm;
    logic hd;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      if (pick < 26) begin
        select_pulse(1'($urandom_range(1)), 1'($urandom_range(1)));
        sent += 2;
      end else if (pick < 50) begin
        dir = 1'($urandom_range(1));
        reps = $urandom_range(4, 1);
        repeat (reps) begin
          step_pulse(dir);
          sent += 2;
        end
      end else if (pick < 70) begin
        reps = $urandom_range(10, 1);
        repeat (reps) push_request(make_item(fdm_pkg::MODE_TICK, 8'($urandom_range(255)),
                                             1'b0, 1'b0, 1'b0));
        sent += reps;
      end else if (pick < 84) begin
        reps = $urandom_range(12, 1);
        repeat (reps) push_request(make_item(fdm_pkg::MODE_BYTE, 8'($urandom_range(255)),
                                             1'b0, 1'b0, 1'b0));
        sent += reps;
      end else if (pick < 91) begin
        sm = 1'($urandom_range(1));
        hd = 1'($urandom_range(1));
        if ($urandom_range(9) < 7) begin
          sm = (m_cfg.drive_kind == fdm_pkg::KIND_DD525);
          if (m_cfg.drive_kind != fdm_pkg::KIND_HD35) hd = 1'b0;
        end
        push_request(make_item(fdm_pkg::MODE_INSERT, 8'($urandom_range(255)), sm, hd,
                               1'($urandom_range(1))));
        sent++;
      end else if (pick < 95) begin
        push_request(make_item(fdm_pkg::MODE_EJECT, 8'($urandom_range(255)),
                               1'b0, 1'b0, 1'b0));
        sent++;
      end else begin
        push_request(make_item(3'($urandom_range(7)), 8'($urandom_range(255)),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Reset configuration: idle operations, unused modes, insert rules,
  // motor switch, a settled step and one refused by the settle timer.
  task automatic test_directed();
    push_request(make_item(fdm_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    push_request(make_item(fdm_pkg::MODE_BYTE, 8'h00, 1'b0, 1'b0, 1'b0));
    push_request(make_item(fdm_pkg::MODE_EJECT, 8'h00, 1'b0, 1'b0, 1'b0));
    push_request(make_item(MODE_SPARE_FIRST, 8'hFF, 1'b1, 1'b1, 1'b1));
    push_request(make_item(MODE_SPARE_MID, 8'hFF, 1'b1, 1'b1, 1'b1));
    push_request(make_item(MODE_SPARE_LAST, 8'hFF, 1'b1, 1'b1, 1'b1));
    push_request(make_item(fdm_pkg::MODE_INSERT, 8'h00, 1'b1, 1'b0, 1'b0));
    push_request(make_item(fdm_pkg::MODE_INSERT, 8'h00, 1'b0, 1'b1, 1'b0));
    push_request(make_item(fdm_pkg::MODE_INSERT, 8'h00, 1'b0, 1'b0, 1'b1));
    push_request(make_item(fdm_pkg::MODE_INSERT, 8'h00, 1'b0, 1'b0, 1'b0));
    select_pulse(1'b1, 1'b0);
    step_pulse(1'b0);
    step_pulse(1'b1);
    push_request(make_item(fdm_pkg::MODE_BYTE, 8'h00, 1'b0, 1'b0, 1'b0));
    push_request(make_item(fdm_pkg::MODE_TICK, 8'h00, 1'b0, 1'b0, 1'b0));
    push_port(8'h00);
    push_port(8'hFF);
    select_pulse(1'b1, 1'b1);
    push_request(make_item(fdm_pkg::MODE_EJECT, 8'h00, 1'b0, 1'b0, 1'b0));
    push_request(make_item(fdm_pkg::MODE_EJECT, 8'h00, 1'b0, 1'b0, 1'b0));
  endtask

  // Instant mechanics: walk the head past both end stops
  task automatic test_head_sweep();
    program_setting('{drive_number: 2'd1, drive_kind: fdm_pkg::KIND_DD525,
                      mechanics_on: 1'b0,
                      spin_up_rate: 16'd1, spin_down_rate: fdm_pkg::FULL_SPEED,
                      step_settle_ticks: fdm_pkg::SETTLE_MAX, track_bytes: 14'd1});
    select_pulse(1'b0, 1'b0);
    repeat (int'(fdm_pkg::MAX_CYLINDER) + 3) step_pulse(1'b0);
    repeat (4) push_request(make_item(fdm_pkg::MODE_BYTE, 8'h00, 1'b0, 1'b0, 1'b0));
    repeat (int'(fdm_pkg::MAX_CYLINDER) + 3) step_pulse(1'b1);
  endtask

  // Register extremes: kind three, rates zero and full, empty and longest track
  task automatic test_register_extremes();
    program_setting('{drive_number: 2'd3, drive_kind: KIND_NONE, mechanics_on: 1'b1,
                      spin_up_rate: 16'd0, spin_down_rate: 16'd0,
                      step_settle_ticks: fdm_pkg::SETTLE_MAX, track_bytes: 14'd0});
    run_traffic(80);
    program_setting('{drive_number: 2'd2, drive_kind: fdm_pkg::KIND_HD35,
                      mechanics_on: 1'b1,
                      spin_up_rate: fdm_pkg::FULL_SPEED,
                      spin_down_rate: fdm_pkg::FULL_SPEED,
                      step_settle_ticks: 11'd0, track_bytes: 14'h3FFF});
    run_traffic(80);
    program_setting('{drive_number: 2'd0, drive_kind: fdm_pkg::KIND_DD35,
                      mechanics_on: 1'b1,
                      spin_up_rate: 16'd1, spin_down_rate: 16'd1,
                      step_settle_ticks: 11'd3, track_bytes: 14'd5});
    run_traffic(60);
  endtask

  task automatic test_random_settings(input int settings, input int per_setting);
    repeat (settings) begin
      program_setting(random_setting());
      run_traffic(per_setting);
    end
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    stall_request = 80;
    repeat (14) push_request(make_item(3'($urandom_range(2, 1)), 8'($urandom_range(255)),
                                       1'b0, 1'b0, 1'b0));
  endtask

  initial begin
    reset_model();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_head_sweep();
    test_register_extremes();
    test_random_settings(2, 150);

    tx_idle_pct = 45;
    rx_idle_pct = 15;
    test_random_settings(4, 150);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_backpressure();
    test_random_settings(3, 120);

    wait_drive_quiet();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fdm_pkg.sv
rtl/fdm_cfg.sv
rtl/fdm_core.sv
rtl/floppy_drive_mechanics_unit.sv
verif/tb_floppy_drive_mechanics_unit.sv
